[src/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, codes and constants shared by the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned TAB_STOP_DEF  = 8;
  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 4;

  localparam int unsigned ADV_W = 9;  // column plus one tab advance, up to 255 + 64

  localparam logic [7:0] WIDTH_RST  = 8'd80;
  localparam logic [7:0] HEIGHT_RST = 8'd25;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_NL  = 8'd10;

  localparam logic ACT_CHAR   = 1'b0;
  localparam logic ACT_SETPOS = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_SETPOS  = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_TAB     = 2'd2,
    OP_PRINT   = 2'd3
  } op_t;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic [7:0] new_col;
    logic [7:0] new_row;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] glyph;
    logic [7:0] row;
    logic [7:0] col;
    logic       ok;
    logic       last;
  } out_word_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [7:0] nc;
    logic [7:0] nr;
  } cmd_t;

  // effective screen size, never zero
  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
  } scr_cfg_t;

  typedef logic [ADV_W-1:0] tab_lut_t [256];

  // next tab stop for every column, built with a running remainder
  function automatic tab_lut_t build_tab_lut(input int unsigned ts);
    tab_lut_t    lut;
    int unsigned m;
    m = 0;
    for (int unsigned i = 0; i < 256; i++) begin
      lut[i] = ADV_W'(i + ts - m);
      if (m + 1 == ts) begin
        m = 0;
      end else begin
        m = m + 1;
      end
    end
    return lut;
  endfunction

endpackage

[src/tcc_fifo.sv]
// ----------------------------------------------------------------------------
// tcc_fifo
// Small first-word-fall-through queue held in registers.
// ----------------------------------------------------------------------------
module tcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FullCnt);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[src/tcc_front.sv]
// ----------------------------------------------------------------------------
// tcc_front
// Accepts input words, drops NUL characters and turns the rest into commands.
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic            push,
  input  tcc_pkg::in_word_t in_word,
  input  logic            cmd_full,
  output logic            cmd_push,
  output tcc_pkg::cmd_t   cmd
);
  import tcc_pkg::*;

  logic drop;

  assign drop = (in_word.action == ACT_CHAR) && (in_word.char_code == CHAR_NUL);

  assign cmd_push = push && !cmd_full && !drop;

  always_comb begin
    cmd.ch = in_word.char_code;
    cmd.nc = in_word.new_col;
    cmd.nr = in_word.new_row;
    if (in_word.action == ACT_SETPOS) begin
      cmd.op = OP_SETPOS;
    end else if (in_word.char_code == CHAR_NL) begin
      cmd.op = OP_NEWLINE;
    end else if (in_word.char_code == CHAR_TAB) begin
      cmd.op = OP_TAB;
    end else begin
      cmd.op = OP_PRINT;
    end
  end

endmodule

[src/tcc_back.sv]
// ----------------------------------------------------------------------------
// tcc_back
// Holds the cursor and executes commands, at most one result word per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcc_pkg::scr_cfg_t   scr,
  input  logic                cmd_valid,
  input  tcc_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output tcc_pkg::out_word_t  res_word
);
  import tcc_pkg::*;

  localparam tab_lut_t TabLut = build_tab_lut(TAB_STOP);

  logic [7:0]       col_r, col_nxt;
  logic [7:0]       row_r, row_nxt;
  logic [7:0]       row_adv;
  logic [ADV_W-1:0] tab_adv;
  logic             wrap;
  logic [7:0]       pcol, prow;
  logic             act;

  assign row_adv = (row_r == 8'hFF) ? row_r : row_r + 8'd1;  // saturating
  assign tab_adv = TabLut[col_r];
  assign wrap    = (col_r >= scr.width);
  assign pcol    = wrap ? 8'd0 : col_r;
  assign prow    = wrap ? row_adv : row_r;

  // newline and tab never write a result, so they run even with the queue full
  assign act = cmd_valid && (!res_full || cmd.op == OP_NEWLINE || cmd.op == OP_TAB);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res_word = '0;
    if (act) begin
      unique case (cmd.op)
        OP_SETPOS: begin
          res_push      = 1'b1;
          res_word.kind = KIND_STATUS;
          res_word.ok   = (cmd.nc < scr.width) && (cmd.nr < scr.height);
          res_word.last = 1'b1;
          cmd_pop       = 1'b1;
          if (res_word.ok) begin
            col_nxt = cmd.nc;
            row_nxt = cmd.nr;
          end
        end
        OP_NEWLINE: begin
          col_nxt = 8'd0;
          row_nxt = row_adv;
          cmd_pop = 1'b1;
        end
        OP_TAB: begin
          cmd_pop = 1'b1;
          if (tab_adv >= {1'b0, scr.width}) begin
            col_nxt = 8'd0;
            row_nxt = row_adv;
          end else begin
            col_nxt = tab_adv[7:0];
          end
        end
        OP_PRINT: begin
          res_push = 1'b1;
          if (prow >= scr.height) begin
            // scroll first, keep the command so the glyph goes out after the scroll
            res_word.kind = KIND_SCROLL;
            col_nxt       = pcol;
            row_nxt       = scr.height - 8'd1;
          end else begin
            res_word.kind  = KIND_GLYPH;
            res_word.glyph = cmd.ch;
            res_word.row   = prow;
            res_word.col   = pcol;
            res_word.last  = 1'b1;
            col_nxt        = pcol + 8'd1;
            row_nxt        = prow;
            cmd_pop        = 1'b1;
          end
        end
        default: begin
          cmd_pop = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[src/text_console_cursor_engine_top.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text-mode cursor tracker: turns character words into glyph, scroll and
// position status words.
//
//   channel   ports                          handshake
//   input     push, full, in_word            taken when push && !full
//   result    pop, empty, out_word           taken when pop && !empty
//   config    cfg_we, cfg_idx, cfg_wdata     written when cfg_we
//
// The front classifies one word per cycle into a command queue while it has
// room; the back retires one command per cycle unless the result queue stalls
// it, and a character that scrolls gives its scroll word before its glyph.
// A result passes the command queue and the result queue to reach out_word.
// Characters and set-position words wait in the back while the result queue
// is full; newline and tab retire anyway. full follows the command queue.
// Reset puts the cursor at row 0, column 0, the screen at 80 x 25 and
// empties both queues.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
  parameter int unsigned TAB_STOP  = tcc_pkg::TAB_STOP_DEF,
  parameter int unsigned CMD_DEPTH = tcc_pkg::CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = tcc_pkg::RES_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tcc_pkg::in_word_t  in_word,
  input  logic               pop,
  output logic               empty,
  output tcc_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [7:0]         cfg_wdata
);
  import tcc_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(out_word_t);

  logic [7:0] width_r, height_r;
  scr_cfg_t   scr;

  logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t            cmd_in, cmd_head;
  logic [CmdW-1:0] cmd_dout;

  logic            res_push, res_full;
  out_word_t       res_word;
  logic [ResW-1:0] res_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default:        width_r  <= width_r;
      endcase
    end
  end

  // a zero register counts as one
  assign scr.width  = (width_r == 8'd0) ? 8'd1 : width_r;
  assign scr.height = (height_r == 8'd0) ? 8'd1 : height_r;

  tcc_front u_front (
    .push     (push),
    .in_word  (in_word),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  tcc_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_dout);
  assign full     = cmd_full;

  tcc_back #(
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .scr       (scr),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  tcc_fifo #(
    .WIDTH (ResW),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_word = out_word_t'(res_dout);

  // a scroll keeps its character at the head of the command queue
  a_scroll_keeps_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_word.kind == KIND_SCROLL |=> !cmd_empty)
    else $error("command lost after scroll");

  // a scroll is never the final word of its character
  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_word.kind == KIND_SCROLL |-> !res_word.last && !cmd_pop)
    else $error("scroll marked last or popped its command");

  // glyphs always land on the screen
  a_glyph_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_word.kind == KIND_GLYPH |->
      res_word.row < scr.height && res_word.col < scr.width)
    else $error("glyph written off screen");

  // nothing is written into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_full |-> !res_push)
    else $error("result queue overflow");

endmodule
